/* design/bst_pkg.sv */
package bst_pkg;

	localparam int POOL_NODES = 1024;
	localparam int IDX_W = $clog2(POOL_NODES);
	localparam int LINK_W = IDX_W + 1;
	localparam int KEY_W = 23;
	localparam int CNT_W = 24;
	localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(POOL_NODES);
	localparam logic [KEY_W:0] ID_END = 24'd8388608;
	localparam logic [KEY_W-1:0] STRIDE_RST = 23'd4194304;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DUP = 2'd3;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [CNT_W-1:0] payload;
		logic [LINK_W-1:0] left;
		logic [LINK_W-1:0] right;
	} node_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		node_t wdata;
		logic re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

endpackage

/* design/bst_record_store_with_id_generator.sv */
// Channel  Dir  Signals                              Handshake
// request  in   op, doc_id, wcount                   start & !busy
// result   out  status, key_out, count_out           done (one cycle)
// A lookup visits v nodes, each with a memory read (S_READ) then a compare (S_CMP);
// busy ends with S_DONE on a hit or a miss, and done is registered in S_DONE.
// An add runs generator steps (S_GEN), a walk for every key it tries, the insert
// walk, then links the parent (S_LINK, if any), writes the node (S_NODE) and answers.
// A full pool goes straight from S_IDLE to S_DONE. Reset clears control and generator state;
// node memory is not cleared. The receiver cannot stall; done pulses once per request.
module bst_record_store_with_id_generator (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic op,
	input logic [22:0] doc_id,
	input logic [23:0] wcount,
	output logic done,
	output logic [1:0] status,
	output logic [22:0] key_out,
	output logic [23:0] count_out
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_GEN   = 7'b0000010,
		S_READ  = 7'b0000100,
		S_CMP   = 7'b0001000,
		S_LINK  = 7'b0010000,
		S_NODE  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	localparam int IW = bst_pkg::IDX_W;
	localparam int LW = bst_pkg::LINK_W;
	localparam int KW = bst_pkg::KEY_W;

	state_t state_q;
	logic op_q;
	logic gen_q;
	logic [KW-1:0] key_q;
	logic [23:0] wc_q;
	logic [LW-1:0] used_q;
	logic [KW-1:0] next_q;
	logic [KW-1:0] stride_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] hops_q;
	logic [IW-1:0] parent_q;
	logic left_q;
	logic has_parent_q;
	bst_pkg::node_t pnode_q;
	bst_pkg::mem_req_t req;
	bst_pkg::node_t rdata;

	logic [KW:0] sum;
	logic cur_ok;
	logic [LW-1:0] nxt;

	bst_node_ram u_ram (.clk(clk), .req(req), .rdata(rdata));

	assign busy = (state_q != S_IDLE);
	assign sum = {1'b0, next_q} + {1'b0, stride_q};
	assign cur_ok = (cur_q < used_q) && (hops_q <= used_q);
	assign nxt = (rdata.key > key_q) ? rdata.left : rdata.right;

	always_comb begin
		req = '0;
		req.raddr = cur_q[IW-1:0];
		req.re = (state_q == S_READ);
		case (state_q)
			S_LINK: begin
				req.we = 1'b1;
				req.waddr = parent_q;
				req.wdata = pnode_q;
				if (left_q) begin
					req.wdata.left = used_q;
				end else begin
					req.wdata.right = used_q;
				end
			end
			S_NODE: begin
				req.we = 1'b1;
				req.waddr = used_q[IW-1:0];
				req.wdata.key = key_q;
				req.wdata.payload = wc_q;
				req.wdata.left = bst_pkg::NO_LINK;
				req.wdata.right = bst_pkg::NO_LINK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			next_q <= '0;
			stride_q <= bst_pkg::STRIDE_RST;
			done <= 1'b0;
			status <= '0;
			key_out <= '0;
			count_out <= '0;
			op_q <= 1'b0;
			gen_q <= 1'b0;
			key_q <= '0;
			wc_q <= '0;
			cur_q <= '0;
			hops_q <= '0;
			parent_q <= '0;
			left_q <= 1'b0;
			has_parent_q <= 1'b0;
			pnode_q <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q <= op;
						wc_q <= wcount;
						key_q <= doc_id;
						if (op == bst_pkg::OP_LOOKUP) begin
							gen_q <= 1'b0;
							cur_q <= '0;
							hops_q <= '0;
							state_q <= S_READ;
						end else if (used_q >= bst_pkg::NO_LINK) begin
							status <= bst_pkg::ST_FULL;
							key_out <= '0;
							count_out <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_GEN;
						end
					end
				end
				S_GEN: begin
					cur_q <= '0;
					hops_q <= '0;
					has_parent_q <= 1'b0;
					if (sum >= bst_pkg::ID_END) begin
						stride_q <= stride_q >> 1;
						next_q <= stride_q >> 1;
					end else if (stride_q == '0) begin
						key_q <= next_q;
						gen_q <= 1'b0;
						state_q <= S_READ;
					end else begin
						key_q <= next_q;
						gen_q <= 1'b1;
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (cur_ok) begin
						state_q <= S_CMP;
					end else if (gen_q) begin
						gen_q <= 1'b0;
						has_parent_q <= 1'b0;
						cur_q <= '0;
						hops_q <= '0;
						if (sum >= bst_pkg::ID_END) begin
							state_q <= S_GEN;
						end
					end else if (op_q == bst_pkg::OP_LOOKUP) begin
						status <= bst_pkg::ST_MISS;
						key_out <= key_q;
						count_out <= '0;
						state_q <= S_DONE;
					end else if (has_parent_q) begin
						state_q <= S_LINK;
					end else begin
						state_q <= S_NODE;
					end
				end
				S_CMP: begin
					if (rdata.key == key_q) begin
						if (gen_q) begin
							next_q <= sum[KW-1:0];
							key_q <= sum[KW-1:0];
							cur_q <= '0;
							hops_q <= '0;
							if (sum + {1'b0, stride_q} >= bst_pkg::ID_END) begin
								gen_q <= 1'b0;
								state_q <= S_GEN;
							end else begin
								state_q <= S_READ;
							end
						end else begin
							key_out <= key_q;
							if (op_q == bst_pkg::OP_LOOKUP) begin
								status <= bst_pkg::ST_OK;
								count_out <= rdata.payload;
							end else begin
								status <= bst_pkg::ST_DUP;
								count_out <= '0;
							end
							state_q <= S_DONE;
						end
					end else begin
						parent_q <= cur_q[IW-1:0];
						pnode_q <= rdata;
						has_parent_q <= 1'b1;
						left_q <= (key_q < rdata.key);
						cur_q <= nxt;
						hops_q <= hops_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_LINK: begin
					state_q <= S_NODE;
				end
				S_NODE: begin
					used_q <= used_q + 1'b1;
					status <= bst_pkg::ST_OK;
					key_out <= key_q;
					count_out <= '0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= bst_pkg::NO_LINK) else $error("pool count overflow");
	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == bst_pkg::ST_FULL) |-> $stable(used_q))
		else $error("full pool changed");
	a_grow_one: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> (used_q == $past(used_q) + 1'b1))
		else $error("pool grew by more than one");
`endif

endmodule

/* design/bst_node_ram.sv */
module bst_node_ram (
	input logic clk,
	input bst_pkg::mem_req_t req,
	output bst_pkg::node_t rdata
);

	bst_pkg::node_t mem [bst_pkg::POOL_NODES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule
